// ===== rtl/core/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg
// shared constants and types for the windowed range position core
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int HELD_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int WINDOW_W      = 7;
  localparam int SPAN_W        = (HELD_W > WINDOW_W + 1) ? HELD_W : WINDOW_W + 1;
  localparam int PRICE_W       = 32;
  localparam int FRAC_W        = 16;
  localparam int POS_W         = FRAC_W + 1;
  localparam int DIV_CNT_W     = $clog2(FRAC_W + 1);

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);
  localparam logic [POS_W-1:0]    POS_FULL     = POS_W'(1) << FRAC_W;

  typedef struct packed {
    logic               start;
    logic [PRICE_W-1:0] numer;
    logic [PRICE_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/wrp_if.sv =====
// ----------------------------------------------------------------------------
// wrp_if
// request channels of the windowed range position core
// ----------------------------------------------------------------------------
interface wrp_bar_if;
  logic                        valid;
  logic                        ready;
  logic [wrp_pkg::PRICE_W-1:0] bar_high;
  logic [wrp_pkg::PRICE_W-1:0] bar_low;
  logic [wrp_pkg::PRICE_W-1:0] bar_close;
  logic                        replaces_last;

  modport source (output valid, bar_high, bar_low, bar_close, replaces_last, input ready);
  modport sink (input valid, bar_high, bar_low, bar_close, replaces_last, output ready);
endinterface

interface wrp_result_if;
  logic                        valid;
  logic                        ready;
  logic [wrp_pkg::POS_W-1:0]   position;
  logic [wrp_pkg::PRICE_W-1:0] range_high;
  logic [wrp_pkg::PRICE_W-1:0] range_low;

  modport source (output valid, position, range_high, range_low, input ready);
  modport sink (input valid, position, range_high, range_low, output ready);
endinterface

// ===== rtl/core/wrp_ram.sv =====
// ----------------------------------------------------------------------------
// wrp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wrp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wrp_div.sv =====
// ----------------------------------------------------------------------------
// wrp_div
// restoring divider, one quotient bit per cycle, fractional quotient
// ----------------------------------------------------------------------------
module wrp_div (
  input  logic              clk,
  input  logic              rst,
  input  wrp_pkg::div_req_t req,
  output wrp_pkg::div_rsp_t rsp
);

  logic                                 busy;
  logic [wrp_pkg::DIV_CNT_W-1:0]        count;
  logic [wrp_pkg::PRICE_W-1:0]          rem;
  logic [wrp_pkg::PRICE_W-1:0]          denom;
  logic [wrp_pkg::FRAC_W-1:0]           quo;
  logic [wrp_pkg::PRICE_W:0]            shifted;
  logic [wrp_pkg::PRICE_W:0]            diff;
  logic                                 fits;
  logic                                 done;

  // remainder stays below the divisor, so one extra bit holds the shift
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, denom};
  assign fits    = shifted >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= wrp_pkg::DIV_CNT_W'(wrp_pkg::FRAC_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == wrp_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.numer;
      denom <= req.denom;
      quo   <= '0;
    end else if (busy) begin
      rem <= fits ? diff[wrp_pkg::PRICE_W-1:0] : shifted[wrp_pkg::PRICE_W-1:0];
      quo <= {quo[wrp_pkg::FRAC_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/windowed_range_position_core.sv =====
// ----------------------------------------------------------------------------
// windowed_range_position_core
// stochastic %K: close position within the high/low range of recent bars
// ----------------------------------------------------------------------------
// bar channel: one request per price bar (high, low, close, replaces_last).
// a bar either appends to the history ring or overwrites the newest bar.
// result channel: one request per bar with the window's greatest high,
// least low and the close position as unsigned q1.16 (65536 = top).
// cfg_we/cfg_wdata write window_bars; write it only while the core is idle.
// one bar is worked on at a time: bar.ready is high only in idle.
// span = min(window_bars+1, bars held). after a bar is taken: a write state
// stores it, a scan state reads span bars from the ram through one compare
// unit, a decide state checks the range, and the serial divider runs (skipped
// when the position is 0 or full scale) before the result is valid.
// the result is held in its output register until the receiver takes it;
// a stalled receiver keeps the core from taking the next bar.
// reset (rst, synchronous) empties the history, sets window_bars to 60.
// ----------------------------------------------------------------------------
module windowed_range_position_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wrp_pkg::WINDOW_W-1:0] cfg_wdata,
  wrp_bar_if.sink                      bar,
  wrp_result_if.source                 result
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WRITE  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_OUTPUT = 6'b100000
  } state_t;

  state_t                        state;
  logic [wrp_pkg::WINDOW_W-1:0]  window_bars;
  logic [wrp_pkg::SLOT_W-1:0]    newest_slot;
  logic [wrp_pkg::HELD_W-1:0]    bars_held;
  logic [wrp_pkg::PRICE_W-1:0]   high_in;
  logic [wrp_pkg::PRICE_W-1:0]   low_in;
  logic [wrp_pkg::PRICE_W-1:0]   close_in;
  logic [wrp_pkg::SPAN_W-1:0]    span;
  logic [wrp_pkg::SPAN_W-1:0]    issue_idx;
  logic                          rd_pending;
  logic [wrp_pkg::PRICE_W-1:0]   hi_acc;
  logic [wrp_pkg::PRICE_W-1:0]   lo_acc;
  logic [wrp_pkg::POS_W-1:0]     position;

  logic [wrp_pkg::SLOT_W-1:0]    slot_inc;
  logic [wrp_pkg::SPAN_W-1:0]    win_span;
  logic [wrp_pkg::SPAN_W-1:0]    held_span;
  logic [wrp_pkg::SLOT_W-1:0]    offset;
  logic [wrp_pkg::SLOT_W-1:0]    raddr;
  logic [2*wrp_pkg::PRICE_W-1:0] rdata;
  logic [wrp_pkg::PRICE_W-1:0]   rd_high;
  logic [wrp_pkg::PRICE_W-1:0]   rd_low;
  logic                          issue;
  logic                          range_empty;
  logic                          close_top;
  wrp_pkg::div_req_t             div_req;
  wrp_pkg::div_rsp_t             div_rsp;

  assign slot_inc = (newest_slot == wrp_pkg::SLOT_W'(wrp_pkg::HISTORY_DEPTH - 1))
                    ? '0 : newest_slot + 1'b1;
  assign win_span  = wrp_pkg::SPAN_W'(window_bars) + wrp_pkg::SPAN_W'(1);
  assign held_span = wrp_pkg::SPAN_W'(bars_held);

  // walk back from the newest slot, wrapping round the ring
  assign offset = issue_idx[wrp_pkg::SLOT_W-1:0];
  assign raddr  = (newest_slot >= offset) ? newest_slot - offset
                : wrp_pkg::SLOT_W'({1'b0, newest_slot}
                  + (wrp_pkg::SLOT_W + 1)'(wrp_pkg::HISTORY_DEPTH) - {1'b0, offset});
  assign issue  = issue_idx < span;

  assign rd_high = rdata[2*wrp_pkg::PRICE_W-1:wrp_pkg::PRICE_W];
  assign rd_low  = rdata[wrp_pkg::PRICE_W-1:0];

  assign range_empty = (hi_acc <= lo_acc) || (close_in <= lo_acc);
  assign close_top   = close_in >= hi_acc;

  assign div_req.start = (state == S_DECIDE) && !range_empty && !close_top;
  assign div_req.numer = close_in - lo_acc;
  assign div_req.denom = hi_acc - lo_acc;

  wrp_ram #(
    .WIDTH (2 * wrp_pkg::PRICE_W),
    .DEPTH (wrp_pkg::HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (newest_slot),
    .wdata ({high_in, low_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  wrp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bars <= wrp_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_bars <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      newest_slot <= '0;
      bars_held   <= '0;
      rd_pending  <= 1'b0;
      issue_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (bar.valid) begin
            // replace with an empty history acts as an append at slot zero
            if (bars_held == '0) begin
              newest_slot <= '0;
              bars_held   <= wrp_pkg::HELD_W'(1);
            end else if (!bar.replaces_last) begin
              newest_slot <= slot_inc;
              if (bars_held < wrp_pkg::HELD_W'(wrp_pkg::HISTORY_DEPTH)) begin
                bars_held <= bars_held + 1'b1;
              end
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          issue_idx  <= '0;
          rd_pending <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          rd_pending <= issue;
          if (issue) begin
            issue_idx <= issue_idx + 1'b1;
          end else if (!rd_pending) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= (range_empty || close_top) ? S_OUTPUT : S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            state <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && bar.valid) begin
      high_in  <= bar.bar_high;
      low_in   <= bar.bar_low;
      close_in <= bar.bar_close;
    end
    if (state == S_WRITE) begin
      span   <= (win_span > held_span) ? held_span : win_span;
      hi_acc <= '0;
      lo_acc <= '1;
    end
    if (state == S_SCAN && rd_pending) begin
      if (rd_high > hi_acc) begin
        hi_acc <= rd_high;
      end
      if (rd_low < lo_acc) begin
        lo_acc <= rd_low;
      end
    end
    if (state == S_DECIDE) begin
      position <= range_empty ? '0 : wrp_pkg::POS_FULL;
    end
    if (state == S_DIVIDE && div_rsp.done) begin
      position <= {1'b0, div_rsp.quotient};
    end
  end

  assign bar.ready         = (state == S_IDLE);
  assign result.valid      = (state == S_OUTPUT);
  assign result.position   = position;
  assign result.range_high = hi_acc;
  assign result.range_low  = lo_acc;

endmodule

// ===== rtl/core/wrp_checker.sv =====
// ----------------------------------------------------------------------------
// wrp_checker
// port level checks for the windowed range position core
// ----------------------------------------------------------------------------
module wrp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        bar_valid,
  input logic                        bar_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [wrp_pkg::POS_W-1:0]   position,
  input logic [wrp_pkg::PRICE_W-1:0] range_high,
  input logic [wrp_pkg::PRICE_W-1:0] range_low
);

  // one bar in flight: taking a bar closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (bar_valid && bar_ready) |=> !bar_ready)
    else $error("bar taken while another is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(result_valid && bar_ready))
    else $error("input open while a result waits");

  a_empty_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (range_high <= range_low)) |-> (position == '0))
    else $error("non-zero position for an empty range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!result_valid && bar_ready))
    else $error("core not idle after reset");

  // a result that is not taken stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(position)))
    else $error("stalled result changed");

endmodule

bind windowed_range_position_core wrp_checker u_wrp_checker (
  .clk          (clk),
  .rst          (rst),
  .bar_valid    (bar.valid),
  .bar_ready    (bar.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .position     (result.position),
  .range_high   (result.range_high),
  .range_low    (result.range_low)
);
